FILE: sv/fupe_pkg.sv
// ----------------------------------------------------------------------------
// fupe_pkg: shared types and constants of the file URL percent encoder
// Item kinds, queue command format, character constants and small helpers.
// ----------------------------------------------------------------------------
package fupe_pkg;

  localparam int CAP_W           = 15;
  localparam int CNT_W           = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 15'h7FFF;

  // item kinds on the input tuser field
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // character constants
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;

  // work handed from the front end to the character sequencer
  typedef enum logic [1:0] {
    OP_PREFIX,
    OP_CHAR,
    OP_ESC,
    OP_FAIL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h69; // i
      3'd2:    c = 8'h6C; // l
      3'd3:    c = 8'h65; // e
      3'd4:    c = CH_COLON;
      default: c = CH_SLASH;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] c;
    if (v > 4'd9) c = CH_UA - 8'd10 + {4'h0, v};
    else          c = CH_ZERO + {4'h0, v};
    return c;
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    logic p;
    p = (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) ||
        (b >= CH_ZERO && b <= CH_NINE) || b == CH_STAR || b == CH_DASH ||
        b == CH_DOT || b == CH_UNDER || b == CH_COLON;
    return p;
  endfunction

endpackage

FILE: sv/fupe_front.sv
// ----------------------------------------------------------------------------
// fupe_front: input classifier
// Accepts one transaction per cycle unless queue is full; checks room against
// capacity, keeps count and UTF-8 state, queues one command per result group.
// ----------------------------------------------------------------------------
module fupe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 cfg_we,
  input  logic [fupe_pkg::CAP_W-1:0] cfg_wdata,
  input  fupe_pkg::q_status_t  q_status,
  output logic                 push,
  output fupe_pkg::cmd_t       push_cmd
);
  import fupe_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] cw_r, cw_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic             err_r, err_nxt;

  logic             accept;
  logic [7:0]       b;
  logic [1:0]       lead_extra;
  logic [3:0]       need;
  logic             room;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_comb begin
    if (b >= LEAD2_LO && b <= LEAD2_HI)      lead_extra = 2'd1;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) lead_extra = 2'd2;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) lead_extra = 2'd3;
    else                                     lead_extra = 2'd0;
  end

  // room needed for this item; a lead byte reserves its whole sequence
  always_comb begin
    if (in_tuser == KIND_DATA && pend_r == 2'd0 && b > ASCII_MAX) begin
      unique case (lead_extra)
        2'd1:    need = 4'd6;
        2'd2:    need = 4'd9;
        default: need = 4'd12;
      endcase
    end else if (in_tuser == KIND_DATA && b != CH_SLASH && b != CH_BSLASH &&
                 !is_plain(b)) begin
      need = 4'd3;
    end else begin
      need = 4'd1;
    end
  end

  assign room = ({1'b0, cw_r} + {13'd0, need}) <= {2'b00, capacity_r};

  always_comb begin
    push     = 1'b0;
    push_cmd = '{op: OP_CHAR, ch: CH_NUL};
    cw_nxt   = cw_r;
    pend_nxt = pend_r;
    err_nxt  = err_r;
    if (accept) begin
      unique case (in_tuser)
        KIND_START: begin
          push     = 1'b1;
          push_cmd = '{op: OP_PREFIX, ch: CH_NUL};
          cw_nxt   = CNT_W'(8);
          pend_nxt = 2'd0;
          err_nxt  = 1'b0;
        end
        KIND_DATA: begin
          if (!err_r) begin
            if (pend_r != 2'd0) begin
              // continuation: room was reserved at the lead byte
              push     = 1'b1;
              push_cmd = '{op: OP_ESC, ch: b};
              pend_nxt = pend_r - 2'd1;
              cw_nxt   = cw_r + CNT_W'(3);
            end else if (b > ASCII_MAX && lead_extra == 2'd0) begin
              push = 1'b0; // drop stray high byte
            end else if (!room) begin
              push     = 1'b1;
              push_cmd = '{op: OP_FAIL, ch: CH_NUL};
              err_nxt  = 1'b1;
            end else if (b == CH_SLASH || b == CH_BSLASH) begin
              push     = 1'b1;
              push_cmd = '{op: OP_CHAR, ch: CH_SLASH};
              cw_nxt   = cw_r + CNT_W'(1);
            end else if (is_plain(b)) begin
              push     = 1'b1;
              push_cmd = '{op: OP_CHAR, ch: b};
              cw_nxt   = cw_r + CNT_W'(1);
            end else begin
              push     = 1'b1;
              push_cmd = '{op: OP_ESC, ch: b};
              pend_nxt = lead_extra;
              cw_nxt   = cw_r + CNT_W'(3);
            end
          end
        end
        KIND_END: begin
          if (!err_r) begin
            push = 1'b1;
            if (pend_r != 2'd0 || !room) begin
              push_cmd = '{op: OP_FAIL, ch: CH_NUL};
              err_nxt  = 1'b1;
            end else begin
              push_cmd = '{op: OP_CHAR, ch: CH_NUL};
              cw_nxt   = cw_r + CNT_W'(1);
            end
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      cw_r       <= '0;
      pend_r     <= 2'd0;
      err_r      <= 1'b0;
    end else begin
      if (cfg_we) capacity_r <= cfg_wdata;
      cw_r   <= cw_nxt;
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

FILE: sv/fupe_queue.sv
// ----------------------------------------------------------------------------
// fupe_queue: command queue
// Short first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module fupe_queue #(
  parameter int DEPTH = fupe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fupe_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output fupe_pkg::cmd_t      head,
  output fupe_pkg::q_status_t status
);
  import fupe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

endmodule

FILE: sv/fupe_back.sv
// ----------------------------------------------------------------------------
// fupe_back: character sequencer
// Expands each queued command into output characters, one per cycle while the
// receiver is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module fupe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fupe_pkg::cmd_t      head,
  input  fupe_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [0:0]          out_tuser
);
  import fupe_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic       advance;
  logic       is_last;
  logic [7:0] ch;

  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       fail_r;

  assign advance = !q_status.empty && (!valid_r || out_tready);

  always_comb begin
    unique case (head.op)
      OP_PREFIX: last_idx = 3'd7;
      OP_ESC:    last_idx = 3'd2;
      default:   last_idx = 3'd0;
    endcase
  end

  assign is_last = (idx_r == last_idx);
  assign pop     = advance && is_last;

  always_comb begin
    unique case (head.op)
      OP_PREFIX: ch = prefix_char(idx_r);
      OP_ESC: begin
        if (idx_r == 3'd0)      ch = CH_PERCENT;
        else if (idx_r == 3'd1) ch = hex_digit(head.ch[7:4]);
        else                    ch = hex_digit(head.ch[3:0]);
      end
      OP_CHAR:   ch = head.ch;
      default:   ch = CH_NUL;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (advance) idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (advance)         valid_r <= 1'b1;
      else if (out_tready) valid_r <= 1'b0;
    end
  end

  // hold the payload while the transaction waits
  always_ff @(posedge clk) begin
    if (advance) begin
      char_r <= ch;
      last_r <= is_last;
      fail_r <= (head.op == OP_FAIL);
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = char_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = fail_r;

endmodule

FILE: sv/file_url_percent_encoder_unit.sv
// ----------------------------------------------------------------------------
// file_url_percent_encoder_unit: file URL percent encoder
// The first character of a transaction passes through the command queue and
//   the registered output stage after the input transaction is accepted.
// Throughput: one output character per cycle while the receiver is ready; an
//   input transaction per cycle while the command queue has room, so a byte
//   taking 3 characters paces input to the output port once the queue fills.
// Reset: synchronous, active low; count and UTF-8 state clear, capacity 32767.
// ----------------------------------------------------------------------------
module file_url_percent_encoder_unit #(
  parameter int QUEUE_DEPTH = fupe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic [1:0]                 in_tuser,   // [1:0] kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_char
  output logic                       out_tlast,
  output logic [0:0]                 out_tuser,  // [0] failed
  input  logic                       cfg_we,
  input  logic [fupe_pkg::CAP_W-1:0] cfg_wdata
);
  import fupe_pkg::*;

  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_status;

  fupe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  fupe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  fupe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("command queue both full and empty");

  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == CH_NUL)
    else $error("failure transaction not a single NUL result");

  a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_START |=> !q_status.empty)
    else $error("start transaction not queued");

endmodule

FILE: bench/file_url_percent_encoder_unit_test.sv
// ----------------------------------------------------------------------------
// file_url_percent_encoder_unit_test: self-checking bench for the URL encoder
// Feeds filename byte streams (start, data bytes, end) through the stream
// input while the receiver stalls at random, predicts every output character
// in the bench and compares each output transaction against it. A directed
// table comes first, then random names under several buffer capacities.
// ----------------------------------------------------------------------------
module file_url_percent_encoder_unit_test;
  import fupe_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int N_PROBES      = 30;

  localparam logic [1:0]       KIND_UNUSED = 2'd3;
  localparam logic [CAP_W-1:0] CAP_NONE    = '0;
  localparam logic [CAP_W-1:0] CAP_TIGHT   = 15'd11;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       failed;
  } url_char_t;

  typedef enum logic [1:0] {
    ROW_SEND,
    ROW_SEND_TYPED,
    ROW_SET_CAP
  } row_act_t;

  typedef struct packed {
    row_act_t         act;
    logic [1:0]       kind;
    logic [7:0]       b;
    logic [7:0]       exp_ch;
    logic             exp_fail;
    logic [CAP_W-1:0] cap;
  } probe_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_THIRD,
    RX_MOSTLY
  } rx_mode_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic [1:0]       in_tuser   = KIND_START;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             out_tlast;
  logic [0:0]       out_tuser;
  logic             cfg_we     = 1'b0;
  logic [CAP_W-1:0] cfg_wdata  = '0;

  file_url_percent_encoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // encoder state as the bench sees it
  logic [CAP_W-1:0] buf_cap     = CAP_RESET;
  logic [15:0]      name_len    = '0;
  logic [1:0]       utf8_owed   = '0;
  logic             name_broken = 1'b0;
  url_char_t        url_char_q[$];
  url_char_t        step_out[$];
  string            url_head    = "file:///";
  string            punct       = "*-._:";

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   sent_items     = 0;
  int   burst_left     = 0;
  logic hold_req       = 1'b0;

  probe_row_t probes [N_PROBES] = '{
    '{ROW_SEND_TYPED, KIND_DATA,   CH_LA,     CH_LA,    1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_END,    8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_UNUSED, 8'hFF,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   ASCII_MAX, CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_DATA,   CH_BSLASH, CH_SLASH, 1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_DATA,   CH_SLASH,  CH_SLASH, 1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_DATA,   CH_UZ,     CH_UZ,    1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'h80,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'hFF,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   LEAD2_LO,  CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   CH_UA,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   LEAD4_HI,  CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_END,    8'h00,     CH_NUL,   1'b1, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   CH_LA,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_START,  8'hFF,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   LEAD3_LO,  CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'hFF,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'hF5,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_END,    8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SET_CAP,    KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_DATA,   CH_LA,     CH_NUL,   1'b1, CAP_NONE},
    '{ROW_SET_CAP,    KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_TIGHT},
    '{ROW_SEND,       KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND,       KIND_DATA,   8'h20,     CH_NUL,   1'b0, CAP_NONE},
    '{ROW_SEND_TYPED, KIND_END,    8'h00,     CH_NUL,   1'b1, CAP_NONE},
    '{ROW_SET_CAP,    KIND_START,  8'h00,     CH_NUL,   1'b0, CAP_RESET}
  };

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UA + 8'(v) - 8'd10;
  endfunction

  function automatic logic plain_char(input logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) ||
           (b >= CH_ZERO && b <= CH_NINE) || b == CH_STAR || b == CH_DASH ||
           b == CH_DOT || b == CH_UNDER || b == CH_COLON;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic f);
    step_out.push_back('{c, 1'b0, f});
  endfunction

  function automatic void push_escape(input logic [7:0] b);
    push_char(CH_PERCENT, 1'b0);
    push_char(nibble_char(b[7:4]), 1'b0);
    push_char(nibble_char(b[3:0]), 1'b0);
    name_len = name_len + 16'd3;
  endfunction

  function automatic void push_failure();
    push_char(CH_NUL, 1'b1);
    name_broken = 1'b1;
  endfunction

  // Work out the characters one input transaction produces, into step_out.
  function automatic int encode_item(input logic [1:0] kind, input logic [7:0] b);
    int i;
    int extra;
    step_out.delete();
    case (kind)
      KIND_START: begin
        for (i = 0; i < 8; i++) push_char(url_head[i], 1'b0);
        name_len    = 16'd8;
        utf8_owed   = '0;
        name_broken = 1'b0;
      end
      KIND_DATA: begin
        if (!name_broken) begin
          if (utf8_owed != 2'd0) begin
            // room was reserved by the lead byte
            utf8_owed = utf8_owed - 2'd1;
            push_escape(b);
          end else if (b <= ASCII_MAX) begin
            if (b == CH_SLASH || b == CH_BSLASH || plain_char(b)) begin
              if (int'(name_len) + 1 > int'(buf_cap)) begin
                push_failure();
              end else begin
                push_char((b == CH_BSLASH) ? CH_SLASH : b, 1'b0);
                name_len = name_len + 16'd1;
              end
            end else if (int'(name_len) + 3 > int'(buf_cap)) begin
              push_failure();
            end else begin
              push_escape(b);
            end
          end else begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)      extra = 1;
            else if (b >= LEAD3_LO && b <= LEAD3_HI) extra = 2;
            else if (b >= LEAD4_LO && b <= LEAD4_HI) extra = 3;
            else                                     extra = 0;
            if (extra != 0) begin
              if (int'(name_len) + 3 * (extra + 1) > int'(buf_cap)) begin
                push_failure();
              end else begin
                utf8_owed = 2'(extra);
                push_escape(b);
              end
            end
          end
        end
      end
      KIND_END: begin
        if (!name_broken) begin
          if (utf8_owed != 2'd0 || int'(name_len) + 1 > int'(buf_cap)) begin
            push_failure();
          end else begin
            push_char(CH_NUL, 1'b0);
            name_len = name_len + 16'd1;
          end
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    return step_out.size();
  endfunction

  // Offer one transaction; bursts of random length with random gaps between.
  task automatic drive_item(input logic [1:0] kind, input logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    void'(encode_item(kind, b));
    sent_items++;
    foreach (step_out[i]) url_char_q.push_back(step_out[i]);
    drive_item(kind, b);
  endtask

  // Hold the input until every expected character is out and the block settles.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (url_char_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    buf_cap = v;
  endtask

  function automatic logic [7:0] plain_pick();
    case ($urandom_range(0, 3))
      0:       return CH_UA + 8'($urandom_range(0, 25));
      1:       return CH_LA + 8'($urandom_range(0, 25));
      2:       return CH_ZERO + 8'($urandom_range(0, 9));
      default: return punct[$urandom_range(0, 4)];
    endcase
  endfunction

  // One filename element: plain char, separator, escaped ASCII or UTF-8 sequence.
  task automatic send_token();
    int r;
    int extra;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_item(KIND_DATA, plain_pick());
    end else if (r < 50) begin
      send_item(KIND_DATA, (r % 2 == 0) ? CH_SLASH : CH_BSLASH);
    end else if (r < 70) begin
      send_item(KIND_DATA, 8'($urandom_range(0, 127)));
    end else begin
      extra = $urandom_range(1, 3);
      case (extra)
        1:       lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
        2:       lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
      endcase
      send_item(KIND_DATA, lead);
      repeat (extra) begin
        send_item(KIND_DATA, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(8'h80, 8'hBF)));
      end
    end
  endtask

  task automatic send_names(input int budget);
    int goal;
    int r;
    goal = sent_items + budget;
    while (sent_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_item(KIND_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 10)) send_token();
        r = $urandom_range(0, 99);
        if (r < 90) begin
          send_item(KIND_END, 8'($urandom_range(0, 255)));
        end else if (r < 95) begin
          send_item(KIND_END, 8'($urandom_range(0, 255)));
          send_item(KIND_END, 8'($urandom_range(0, 255)));
        end
      end else if (r < 93) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        // truncated sequence: lead byte, then end right away
        send_item(KIND_DATA, 8'($urandom_range(LEAD2_LO, LEAD4_HI)));
        send_item(KIND_END, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic flag_error(input string what, input url_char_t want, input url_char_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected char %h last %b failed %b, got char %h last %b failed %b",
               what, want.ch, want.last, want.failed, got.ch, got.last, got.failed);
    end
  endtask

  always @(posedge clk) begin : check_results
    url_char_t got;
    url_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tlast, out_tuser[0]};
      if (url_char_q.size() == 0) begin
        flag_error("unexpected transaction", '0, got);
      end else begin
        want = url_char_q.pop_front();
        if (got !== want) flag_error("mismatch", want, got);
      end
    end
  end

  // Receiver: stall pattern is re-picked periodically at random; one long hold-off.
  initial begin
    rx_mode_t rx_mode;
    int       rx_tick;
    logic     hold_done;
    rx_mode   = RX_OPEN;
    rx_tick   = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rx_tick++;
        if (rx_tick % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:  out_tready <= 1'b1;
          RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
          RX_THIRD: out_tready <= (rx_tick % 3 == 0);
          default:  out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      case (probes[i].act)
        ROW_SET_CAP: begin
          drain_results();
          set_capacity(probes[i].cap);
        end
        ROW_SEND_TYPED: begin
          // advance the predicted state, but expect the hand-written character
          void'(encode_item(probes[i].kind, probes[i].b));
          url_char_q.push_back('{probes[i].exp_ch, 1'b1, probes[i].exp_fail});
          drive_item(probes[i].kind, probes[i].b);
        end
        default: send_item(probes[i].kind, probes[i].b);
      endcase
    end

    hold_req = 1'b1;
    send_names(100);
    drain_results();
    set_capacity(15'($urandom_range(9, 60)));
    send_names(90);
    drain_results();
    set_capacity(15'($urandom_range(0, 32767)));
    send_names(90);
    drain_results();
    set_capacity(15'($urandom_range(0, 8)));
    send_names(25);
    drain_results();
    set_capacity(15'($urandom_range(12, 30)));
    send_names(55);
    drain_results();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
